@@ hdl/hrpe_pkg.sv @@
// Shared types and constants for the heart-rate packet encoder.
// Used by hrpe_cell, hrpe_chain and heart_rate_packet_encoder; no dependencies.
package hrpe_pkg;

    // RR-interval FIFO geometry
    localparam int RR_DEPTH   = 16;
    localparam int RR_IDX_W   = (RR_DEPTH > 1) ? $clog2(RR_DEPTH) : 1;
    localparam int RR_CNT_W   = $clog2(RR_DEPTH + 1);
    localparam int RR_W       = 16;
    localparam int MAX_RR_OUT = 16;

    // heart-rate format and flag bits
    localparam logic [15:0] HR_8BIT_MAX      = 16'h00ff;
    localparam logic [7:0]  FLAG_HR_16BIT    = 8'h01 << 0;
    localparam logic [7:0]  FLAG_CONTACT_DET = 8'h01 << 1;
    localparam logic [7:0]  FLAG_CONTACT_SUP = 8'h01 << 2;
    localparam logic [7:0]  FLAG_RR_INCL     = 8'h01 << 4;
    localparam logic [7:0]  MAX_LEN_RESET    = 8'd20;
    localparam logic [1:0]  HDR_LEN_8        = 2'd2;
    localparam logic [1:0]  HDR_LEN_16       = 2'd3;

    // input operation codes
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_RR  = 2'd1;
    localparam logic [1:0] KIND_ACK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_CONTACT_SUP = 2'd0;
    localparam logic [1:0] CFG_CONTACT_DET = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEND
    } t_state;

    // control for the row of FIFO cells
    typedef struct packed {
        logic                shift;
        logic                load;
        logic [RR_IDX_W-1:0] load_idx;
        logic [RR_W-1:0]     data;
    } t_chain_ctrl;

endpackage

@@ hdl/hrpe_cell.sv @@
// One FIFO cell: holds one RR interval, loads a new one or takes its neighbor's.
// Depends on hrpe_pkg for the interval width.
module hrpe_cell
    import hrpe_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic            i_load,
    input  logic [RR_W-1:0] i_load_data,
    input  logic [RR_W-1:0] i_next_data,
    output logic [RR_W-1:0] o_data
);

    logic [RR_W-1:0] r_data;
    logic [RR_W-1:0] n_data;

    // load wins over shift; otherwise hold
    always_comb begin
        if (i_load) begin
            n_data = i_load_data;
        end else if (i_shift) begin
            n_data = i_next_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/hrpe_chain.sv @@
// Row of hrpe_cell instances forming the RR FIFO; cell 0 holds the oldest entry.
// Depends on hrpe_pkg and hrpe_cell.
module hrpe_chain
    import hrpe_pkg::*;
(
    input  logic            i_clk,
    input  t_chain_ctrl     i_ctrl,
    output logic [RR_W-1:0] o_head
);

    logic [RR_W-1:0] w_cell_data [RR_DEPTH];

    // each cell hands its entry toward the head on a shift
    for (genvar g = 0; g < RR_DEPTH; g++) begin : g_cell
        logic [RR_W-1:0] w_next;
        logic            w_load;

        if (g == RR_DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_cell_data[g+1];
        end

        assign w_load = i_ctrl.load && (i_ctrl.load_idx == RR_IDX_W'(g));

        hrpe_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (i_ctrl.shift),
            .i_load      (w_load),
            .i_load_data (i_ctrl.data),
            .i_next_data (w_next),
            .o_data      (w_cell_data[g])
        );
    end

    assign o_head = w_cell_data[0];

endmodule

@@ hdl/heart_rate_packet_encoder.sv @@
// Heart-rate measurement packet encoder with an RR-interval FIFO.
// Depends on hrpe_pkg and hrpe_chain.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries op and value. op add
//   queues an RR interval (the oldest is dropped when the FIFO is full) and
//   returns one acknowledgement. op encode returns a header followed by one
//   result per RR interval placed in the packet, oldest first.
// - Output channel (o_out_valid / i_out_stall) is a single output register.
// - Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) set the contact
//   flags and the packet byte limit; write only while the block is idle.
// - The first result is registered and appears in the cycle after the input transfer.
// - After its header, an encode sends n results, n being the number of RR
//   intervals sent (0 to 16); the FIFO chain pops one cell per cycle while
//   the output is not stalled, and no new input is taken until it is done.
// - A stalled receiver holds the output register and freezes the pop
//   sequence; o_in_stall stays high until the last result is loaded.
// - Reset empties the FIFO and loads the register defaults (limit 20 bytes,
//   contact flags clear). No clearing pass is needed.
module heart_rate_packet_encoder
    import hrpe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [15:0] i_value,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_flags,
    output logic [15:0] o_word,
    output logic [7:0]  o_packet_len,
    output logic        o_buffer_full,
    output logic        o_last
);

    // configuration registers
    logic r_contact_sup;
    logic r_contact_det;
    logic [7:0] r_max_len;

    // control state
    t_state              r_state;
    t_state              n_state;
    logic [RR_CNT_W-1:0] r_count;
    logic [RR_CNT_W-1:0] r_left;
    logic [7:0]          r_pkt_len;
    logic                r_pkt_full;

    // output register
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_flags;
    logic [15:0] r_word;
    logic [7:0]  r_len;
    logic        r_full;
    logic        r_last;

    // handshake and datapath signals
    logic                w_out_free;
    logic                w_in_stall;
    logic                w_in_acc;
    logic                w_add_acc;
    logic                w_enc_acc;
    logic                w_pop;
    logic                w_fifo_full;
    logic                w_add_full;
    logic                w_hr16;
    logic [1:0]          w_hlen;
    logic [7:0]          w_diff;
    logic [7:0]          w_room;
    logic [7:0]          w_n_a;
    logic [7:0]          w_n_b;
    logic [RR_CNT_W-1:0] w_n;
    logic [7:0]          w_plen;
    logic                w_enc_full;
    logic [7:0]          w_flags;
    logic [RR_W-1:0]     w_head;
    t_chain_ctrl         w_chain_ctrl;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact_sup <= 1'b0;
            r_contact_det <= 1'b0;
            r_max_len     <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONTACT_SUP: r_contact_sup <= i_cfg_data[0];
                CFG_CONTACT_DET: r_contact_det <= i_cfg_data[0];
                CFG_MAX_LEN:     r_max_len     <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // size the packet for an encode
    always_comb begin
        w_hr16  = (i_value > HR_8BIT_MAX);
        w_hlen  = w_hr16 ? HDR_LEN_16 : HDR_LEN_8;
        w_diff  = r_max_len - 8'(w_hlen);
        w_room  = (r_max_len >= 8'(w_hlen)) ? {1'b0, w_diff[7:1]} : 8'd0;
        w_n_a   = (w_room < 8'(r_count)) ? w_room : 8'(r_count);
        w_n_b   = (w_n_a < 8'(MAX_RR_OUT)) ? w_n_a : 8'(MAX_RR_OUT);
        w_n     = RR_CNT_W'(w_n_b);
        w_plen  = 8'(w_hlen) + {w_n_b[6:0], 1'b0};
        w_enc_full = ((r_count - w_n) == RR_CNT_W'(RR_DEPTH));
        w_flags = (r_contact_sup ? FLAG_CONTACT_SUP : 8'h00)
                | (r_contact_det ? FLAG_CONTACT_DET : 8'h00)
                | (w_hr16 ? FLAG_HR_16BIT : 8'h00)
                | ((w_n != '0) ? FLAG_RR_INCL : 8'h00);
    end

    assign w_fifo_full = (r_count == RR_CNT_W'(RR_DEPTH));
    assign w_add_full  = w_fifo_full || (r_count == RR_CNT_W'(RR_DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_enc_acc && (w_n != '0)) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_pop && (r_left == RR_CNT_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake and pop control
    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_in_stall = 1'b1;
        w_pop      = 1'b0;
        case (r_state)
            ST_IDLE: w_in_stall = !w_out_free;
            ST_SEND: w_pop      = w_out_free;
            default: ;
        endcase
        w_in_acc  = i_in_valid && !w_in_stall;
        w_add_acc = w_in_acc && (i_op == OP_ADD);
        w_enc_acc = w_in_acc && (i_op == OP_ENCODE);
    end

    // drive the FIFO cells: shift on pop or on add into a full FIFO
    always_comb begin
        w_chain_ctrl.shift    = w_pop || (w_add_acc && w_fifo_full);
        w_chain_ctrl.load     = w_add_acc;
        w_chain_ctrl.load_idx = w_fifo_full ? RR_IDX_W'(RR_DEPTH - 1)
                                            : r_count[RR_IDX_W-1:0];
        w_chain_ctrl.data     = i_value;
    end

    hrpe_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_chain_ctrl),
        .o_head (w_head)
    );

    // advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_add_acc && !w_fifo_full) begin
                r_count <= r_count + RR_CNT_W'(1);
            end else if (w_pop) begin
                r_count <= r_count - RR_CNT_W'(1);
            end
            if (w_enc_acc) begin
                r_left <= w_n;
            end else if (w_pop) begin
                r_left <= r_left - RR_CNT_W'(1);
            end
            if (w_in_acc || w_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // load the output register and hold packet-wide fields
    always_ff @(posedge i_clk) begin
        if (w_enc_acc) begin
            r_pkt_len  <= w_plen;
            r_pkt_full <= w_enc_full;
        end
        if (w_add_acc) begin
            r_kind  <= KIND_ACK;
            r_flags <= 8'h00;
            r_word  <= 16'h0000;
            r_len   <= 8'h00;
            r_full  <= w_add_full;
            r_last  <= 1'b1;
        end else if (w_enc_acc) begin
            r_kind  <= KIND_HDR;
            r_flags <= w_flags;
            r_word  <= i_value;
            r_len   <= w_plen;
            r_full  <= w_enc_full;
            r_last  <= (w_n == '0);
        end else if (w_pop) begin
            r_kind  <= KIND_RR;
            r_flags <= 8'h00;
            r_word  <= w_head;
            r_len   <= r_pkt_len;
            r_full  <= r_pkt_full;
            r_last  <= (r_left == RR_CNT_W'(1));
        end
    end

    assign o_in_stall    = w_in_stall;
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_flags       = r_flags;
    assign o_word        = r_word;
    assign o_packet_len  = r_len;
    assign o_buffer_full = r_full;
    assign o_last        = r_last;

    // the send phase always has intervals left to pop
    a_send_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND) |-> (r_left != '0))
        else $error("send phase with no intervals left");

    // the FIFO never reports more entries than it has cells
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RR_CNT_W'(RR_DEPTH))
        else $error("FIFO count above depth");

    // popping the final interval returns to idle with the last flag set
    a_last_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (r_left == RR_CNT_W'(1))) |=> ((r_state == ST_IDLE) && o_last))
        else $error("final interval did not close the packet");

    // no intervals pop while the FIFO is empty
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (r_count != '0))
        else $error("pop from empty FIFO");

endmodule
